// File: hdl/cid_pkg.sv
// shared types and constants for the combinatorial index decoder
package cid_pkg;

  localparam int unsigned MaxBitsDefault = 64;
  localparam int unsigned DvdWidth       = 72;
  localparam int unsigned DivSteps       = 9;

  typedef struct packed {
    logic [63:0] encoded_value;
    logic [6:0]  bit_count;
    logic [6:0]  ones_count;
    logic [7:0]  symbol;
  } cid_in_t;

  typedef struct packed {
    logic [7:0] symbol_out;
    logic [6:0] position;
    logic       last;
    logic       error;
  } cid_out_t;

  typedef enum logic [1:0] {
    DIV_INIT,
    DIV_HIT,
    DIV_MISS
  } cid_div_sel_e;

  typedef struct packed {
    logic         load;
    logic         bin_one;
    logic         bin_zero;
    logic         bin_from_div;
    logic         div_start;
    cid_div_sel_e div_sel;
    logic         sub;
    logic         col_dec;
    logic         k_dec;
    logic         i_inc;
    logic         emit;
    logic         emit_pos_zero;
    logic         emit_last;
    logic         emit_err;
  } cid_cmd_t;

  typedef struct packed {
    logic bad_item;
    logic no_ones;
    logic rem_nz;
    logic init_done;
    logic scan_done;
    logic k_gt_c;
    logic k_one;
    logic ge;
    logic rem_eq_b;
    logic div_done;
    logic out_free;
  } cid_status_t;

endpackage

// File: hdl/cid_datapath.sv
// datapath: value registers, binomial update divider and result register
module cid_datapath
  import cid_pkg::*;
#(
  parameter int unsigned MaxBits = MaxBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cid_in_t     in_item_i,
  input  cid_cmd_t    cmd_i,
  output cid_status_t st_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output cid_out_t    out_item_o
);

  logic [63:0] rem_q, bin_q;
  logic [6:0]  n_q, r_q, col_q, k_q, i_q;
  logic [7:0]  sym_q;

  logic [DvdWidth-1:0] dvd_q, quo_q;
  logic [6:0]          dsr_q, drem_q;
  logic [3:0]          div_cnt_q;
  logic                div_busy_q;

  logic     out_valid_q;
  cid_out_t out_q;

  logic [6:0]  mult, divisor;
  logic [70:0] prod;
  logic [6:0]  rr;
  logic [7:0]  qbyte;
  logic [7:0]  t;
  logic        div_done;

  // operand selection for the next binomial
  always_comb begin
    case (cmd_i.div_sel)
      DIV_INIT: begin
        mult    = n_q - i_q;
        divisor = i_q + 7'd1;
      end
      DIV_HIT: begin
        mult    = k_q;
        divisor = col_q;
      end
      DIV_MISS: begin
        mult    = col_q - k_q;
        divisor = col_q;
      end
      default: begin
        mult    = '0;
        divisor = 7'd1;
      end
    endcase
  end

  assign prod = {7'd0, bin_q} * {64'd0, mult};

  // eight quotient bits per cycle
  always_comb begin
    rr    = drem_q;
    qbyte = '0;
    t     = '0;
    for (int j = 7; j >= 0; j--) begin
      t = {rr, dvd_q[DvdWidth-8+j]};
      if (t >= {1'b0, dsr_q}) begin
        t        = t - {1'b0, dsr_q};
        qbyte[j] = 1'b1;
      end
      rr = t[6:0];
    end
  end

  assign div_done = div_busy_q && (div_cnt_q == 4'(DivSteps));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_done) begin
      div_busy_q <= 1'b0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q  <= {1'b0, prod};
      dsr_q  <= divisor;
      drem_q <= '0;
      quo_q  <= '0;
    end else if (div_busy_q && !div_done) begin
      dvd_q  <= dvd_q << 8;
      drem_q <= rr;
      quo_q  <= {quo_q[DvdWidth-9:0], qbyte};
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= in_item_i.encoded_value;
      n_q   <= in_item_i.bit_count;
      r_q   <= in_item_i.ones_count;
      col_q <= in_item_i.bit_count;
      k_q   <= in_item_i.ones_count;
      sym_q <= in_item_i.symbol;
      i_q   <= '0;
    end else begin
      if (cmd_i.sub)     rem_q <= rem_q - bin_q;
      if (cmd_i.col_dec) col_q <= col_q - 7'd1;
      if (cmd_i.k_dec)   k_q   <= k_q - 7'd1;
      if (cmd_i.i_inc)   i_q   <= i_q + 7'd1;
    end
    if (cmd_i.bin_one) begin
      bin_q <= 64'd1;
    end else if (cmd_i.bin_zero) begin
      bin_q <= '0;
    end else if (cmd_i.bin_from_div) begin
      bin_q <= quo_q[63:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.symbol_out <= sym_q;
      out_q.position   <= cmd_i.emit_pos_zero ? 7'd0 : (n_q - col_q + 7'd1);
      out_q.last       <= cmd_i.emit_last;
      out_q.error      <= cmd_i.emit_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign st_o.bad_item  = ({25'd0, n_q} > 32'(MaxBits)) || (r_q > n_q);
  assign st_o.no_ones   = (r_q == 7'd0);
  assign st_o.rem_nz    = (rem_q != 64'd0);
  assign st_o.init_done = (i_q == r_q);
  assign st_o.scan_done = (col_q == 7'd0) || (k_q == 7'd0);
  assign st_o.k_gt_c    = (k_q > col_q);
  assign st_o.k_one     = (k_q == 7'd1);
  assign st_o.ge        = (rem_q >= bin_q);
  assign st_o.rem_eq_b  = (rem_q == bin_q);
  assign st_o.div_done  = div_done;
  assign st_o.out_free  = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result written over a stalled item");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy_q)
    else $error("divider restarted while busy");
  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (quo_q[DvdWidth-1:64] == '0))
    else $error("binomial quotient exceeds 64 bits");
`endif

endmodule

// File: hdl/cid_ctrl.sv
// controller state machine for the decoder
module cid_ctrl
  import cid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  cid_status_t st_i,
  output cid_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_IWAIT = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SWAIT = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st_i.bad_item || st_i.no_ones) begin
          if (st_i.out_free) begin
            cmd_o.emit          = 1'b1;
            cmd_o.emit_pos_zero = 1'b1;
            cmd_o.emit_last     = 1'b1;
            cmd_o.emit_err      = st_i.bad_item || st_i.rem_nz;
            state_d             = S_IDLE;
          end
        end else begin
          cmd_o.bin_one = 1'b1;
          state_d       = S_INIT;
        end
      end
      S_INIT: begin
        if (st_i.init_done) begin
          state_d = S_SCAN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_INIT;
          state_d         = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (st_i.div_done) begin
          cmd_o.bin_from_div = 1'b1;
          cmd_o.i_inc        = 1'b1;
          state_d            = S_INIT;
        end
      end
      S_SCAN: begin
        if (st_i.scan_done) begin
          state_d = S_IDLE;
        end else if (st_i.ge) begin
          if (st_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = st_i.k_one;
            cmd_o.emit_err  = st_i.k_one && !st_i.rem_eq_b;
            cmd_o.sub       = 1'b1;
            cmd_o.k_dec     = 1'b1;
            cmd_o.col_dec   = 1'b1;
            if (st_i.k_gt_c) begin
              cmd_o.bin_zero = 1'b1;
            end else begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_HIT;
              state_d         = S_SWAIT;
            end
          end
        end else begin
          cmd_o.col_dec = 1'b1;
          if (st_i.k_gt_c) begin
            cmd_o.bin_zero = 1'b1;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_MISS;
            state_d         = S_SWAIT;
          end
        end
      end
      S_SWAIT: begin
        if (st_i.div_done) begin
          cmd_o.bin_from_div = 1'b1;
          state_d            = S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE))
    else $error("item loaded while busy");
  a_div_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> (state_q == S_IWAIT || state_q == S_SWAIT))
    else $error("divider started without a wait state");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.bin_one, cmd_o.bin_zero, cmd_o.bin_from_div}))
    else $error("conflicting binomial updates");
`endif

endmodule

// File: hdl/combinatorial_index_decoder.sv
// top level of the combinatorial index decoder
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------
//  in      | in        | in_valid_i / in_stall_o | in_item_i  (cid_in_t)
//  out     | out       | out_valid_o/ out_stall_i| out_item_o (cid_out_t)
//
// one item is decoded at a time; each binomial update consists of the divider
// start, 9 divider steps of 8 bits each and the write-back; the shared
// multiply and 8-bit-per-cycle exact divider set how long an item takes from
// its acceptance until the controller is idle again
// reset is asynchronous and active low; it idles the controller and empties
// the result register
// a stall on the output holds the scan at the next found position; a new
// item is taken whenever the controller is idle, even with a result waiting
module combinatorial_index_decoder
  import cid_pkg::*;
#(
  parameter int unsigned MaxBits = MaxBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cid_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cid_out_t out_item_o
);

  // command and status between controller and datapath
  cid_cmd_t    cmd;
  cid_status_t st;

  cid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cid_datapath #(
    .MaxBits (MaxBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
